@@ rtl/etw_pkg.sv @@
`timescale 1ns / 1ps

package etw_pkg;

  localparam int DEFAULT_TIME_BITS  = 16;
  localparam int DEFAULT_VALUE_BITS = 32;

  localparam int NPROP          = 4;
  localparam int DUR_FIELD_BITS = 16;
  localparam int DELTA_BITS     = 16;
  localparam int CMD_BITS       = 2;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 64;
  localparam int HALF_BITS      = 32;

  // progress is Q0.16, one more bit to hold exactly 1.0
  localparam int PROG_BITS = 16;
  localparam int PROG_W    = PROG_BITS + 1;
  localparam logic [PROG_W-1:0] PROG_ONE = PROG_W'(1) << PROG_BITS;

  // eased factor, Q0.32
  localparam int EASE_BITS = 2 * PROG_BITS;

  localparam int OUT_VALUE_BITS = 32;
  localparam int OUT_USED_BITS  = NPROP * OUT_VALUE_BITS + PROG_W + 2;
  localparam int OUT_DATA_BITS  = ((OUT_USED_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_BITS   = OUT_DATA_BITS - OUT_USED_BITS;
  localparam int IN_DATA_BITS   = DELTA_BITS;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_RESET = 2'd3
  } cmd_t;

  localparam logic [CFG_INDEX_BITS-1:0] REG_DURATION   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_BASE = 3'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SQR_GO,
    ST_SQR_WAIT,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_DONE
  } state_t;

endpackage

@@ rtl/etw_divider.sv @@
`timescale 1ns / 1ps

module etw_divider #(
  parameter int T_BITS = etw_pkg::DEFAULT_TIME_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [T_BITS-1:0]         dividend,
  input  logic [T_BITS-1:0]         divisor,
  output logic [etw_pkg::PROG_W-1:0] quotient,
  output logic                      done
);
  import etw_pkg::*;

  localparam int CW = $clog2(PROG_BITS + 1);

  logic [T_BITS:0]    rem;
  logic [T_BITS-1:0]  dvs;
  logic [PROG_BITS-1:0] quo;
  logic [CW-1:0]      cnt;
  logic               busy;

  logic [T_BITS:0] shifted;
  logic            ge;
  logic [T_BITS:0] rem_next;

  // restoring division, one quotient bit per cycle; rem < divisor throughout
  assign shifted  = {rem[T_BITS-1:0], 1'b0};
  assign ge       = shifted >= {1'b0, dvs};
  assign rem_next = ge ? shifted - {1'b0, dvs} : shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (divisor == '0) begin
          quotient <= '0;
          done     <= 1'b1;
        end else if (dividend >= divisor) begin
          quotient <= PROG_ONE;
          done     <= 1'b1;
        end else begin
          rem  <= {1'b0, dividend};
          dvs  <= divisor;
          cnt  <= CW'(PROG_BITS);
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[PROG_BITS-2:0], ge};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy     <= 1'b0;
          done     <= 1'b1;
          quotient <= {1'b0, quo[PROG_BITS-2:0], ge};
        end
      end
    end
  end

endmodule

@@ rtl/etw_serial_mul.sv @@
`timescale 1ns / 1ps

module etw_serial_mul #(
  parameter int A_BITS = etw_pkg::DEFAULT_VALUE_BITS,
  parameter int B_BITS = etw_pkg::EASE_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [A_BITS-1:0]        a,
  input  logic [B_BITS-1:0]        b,
  output logic [A_BITS+B_BITS-1:0] product,
  output logic                     done
);

  localparam int CW = $clog2(B_BITS + 1);

  logic [A_BITS-1:0] a_reg;
  logic [A_BITS:0]   hi;
  logic [B_BITS-1:0] lo;
  logic [CW-1:0]     cnt;
  logic              busy;

  logic [A_BITS:0] t;

  // shift-add, multiplier bits consumed LSB first from lo
  assign t       = hi + (lo[0] ? {1'b0, a_reg} : '0);
  assign product = {hi[A_BITS-1:0], lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_reg <= a;
        hi    <= '0;
        lo    <= b;
        cnt   <= CW'(B_BITS);
        busy  <= 1'b1;
      end else if (busy) begin
        hi  <= {1'b0, t[A_BITS:1]};
        lo  <= {t[0], lo[B_BITS-1:1]};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/eased_tween_engine_top.sv @@
`timescale 1ns / 1ps

// Quadratic ease-in-out tween of four signed Q16.16 properties. Commands come in
// on s_tuser, the tick delta on s_tdata; every transaction produces exactly one
// result transaction. One command is processed at a time and s_tready is high
// only while the engine is idle, but a result waiting in the output register
// does not block the next command. A tick that interpolates runs, from acceptance
// until its result sits in the output register, a 16-step restoring divider
// for progress, a 16-step shift-add square for the ease factor and a 32-step
// shift-add blend run in four parallel lanes, each started from its own launch
// state and awaited in its own wait state. Every other command (and a tick that
// snaps to the end or finds the engine stopped) only runs the divider. The next
// command is accepted in the cycle after the result is loaded; a full output
// register holds the engine until the result drains. Registers are written
// through cfg_we/cfg_index/cfg_data; the user must write them only while no
// command is in flight, as the block itself does not enforce this.

module eased_tween_engine_top #(
  parameter int TIME_BITS  = etw_pkg::DEFAULT_TIME_BITS,
  parameter int VALUE_BITS = etw_pkg::DEFAULT_VALUE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_we,
  input  logic [etw_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [etw_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // command stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [etw_pkg::IN_DATA_BITS-1:0]   s_tdata,  // [15:0] delta
  input  logic [etw_pkg::CMD_BITS-1:0]       s_tuser,  // [1:0] command
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [31:0] opacity_now, [63:32] x_now, [95:64] y_now, [127:96] scale_now,
  // [144:128] progress, [145] running, [146] finished, rest zero
  output logic [etw_pkg::OUT_DATA_BITS-1:0]  m_tdata
);
  import etw_pkg::*;

  localparam int TW = (TIME_BITS < DUR_FIELD_BITS) ? TIME_BITS : DUR_FIELD_BITS;
  localparam int VB = VALUE_BITS;

  state_t state, state_next;

  logic [TW-1:0]     duration;
  logic [TW-1:0]     elapsed;
  logic              active;
  logic              fin;
  logic              interp;
  logic [PROG_W-1:0] prog;
  logic [EASE_BITS-1:0] ease;

  logic [VB-1:0] rng_start [NPROP];
  logic [VB-1:0] rng_end   [NPROP];
  logic [VB-1:0] val       [NPROP];

  logic div_go, sqr_go, mul_go, out_load;
  logic in_acc;
  logic [TW:0] sum;

  logic              div_done;
  logic [PROG_W-1:0] div_q;

  logic                   sqr_done;
  logic                   sqr_low;
  logic [PROG_BITS-1:0]   sqr_r;
  logic [2*PROG_BITS-1:0] sqr_prod;
  logic [EASE_BITS-1:0]   sqr2;
  logic [EASE_BITS-1:0]   ease_next;

  logic [NPROP-1:0]        mul_done;
  logic [VB+EASE_BITS-1:0] mul_prod  [NPROP];
  logic [VB:0]             diff      [NPROP];
  logic [VB-1:0]           mag       [NPROP];
  logic [VB-1:0]           blend_val [NPROP];

  assign in_acc   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign sum      = {1'b0, elapsed} + {1'b0, s_tdata[TW-1:0]};

  // ---------------------------------------------------------------- progress
  etw_divider #(.T_BITS(TW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (elapsed),
    .divisor  (duration),
    .quotient (div_q),
    .done     (div_done)
  );

  // ------------------------------------------------------------ ease factor
  assign sqr_low   = !prog[PROG_BITS-1];
  assign sqr_r     = sqr_low ? prog[PROG_BITS-1:0] : PROG_BITS'(PROG_ONE - prog);
  assign sqr2      = {sqr_prod[2*PROG_BITS-2:0], 1'b0};
  assign ease_next = sqr_low ? sqr2 : (~sqr2) + EASE_BITS'(1);

  etw_serial_mul #(.A_BITS(PROG_BITS), .B_BITS(PROG_BITS)) u_sqr (
    .clk     (clk),
    .rst     (rst),
    .start   (sqr_go),
    .a       (sqr_r),
    .b       (sqr_r),
    .product (sqr_prod),
    .done    (sqr_done)
  );

  // ----------------------------------------------------------- blend lanes
  for (genvar g = 0; g < NPROP; g++) begin : g_lane
    logic [VB-1:0] off;

    assign diff[g] = {rng_end[g][VB-1], rng_end[g]} - {rng_start[g][VB-1], rng_start[g]};
    assign mag[g]  = diff[g][VB] ? VB'(-diff[g]) : diff[g][VB-1:0];
    assign off     = mul_prod[g][VB+EASE_BITS-1:EASE_BITS];
    assign blend_val[g] = diff[g][VB] ? rng_start[g] - off : rng_start[g] + off;

    etw_serial_mul #(.A_BITS(VB), .B_BITS(EASE_BITS)) u_lane (
      .clk     (clk),
      .rst     (rst),
      .start   (mul_go),
      .a       (mag[g]),
      .b       (ease),
      .product (mul_prod[g]),
      .done    (mul_done[g])
    );
  end

  // ------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_go     = 1'b0;
    sqr_go     = 1'b0;
    mul_go     = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        div_go     = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) state_next = interp ? ST_SQR_GO : ST_DONE;
      end
      ST_SQR_GO: begin
        sqr_go     = 1'b1;
        state_next = ST_SQR_WAIT;
      end
      ST_SQR_WAIT: begin
        if (sqr_done) state_next = ST_MUL_GO;
      end
      ST_MUL_GO: begin
        mul_go     = 1'b1;
        state_next = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (&mul_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ----------------------------------------------------------- tween state
  always_ff @(posedge clk) begin
    if (rst) begin
      duration <= '0;
      elapsed  <= '0;
      active   <= 1'b0;
      fin      <= 1'b0;
      interp   <= 1'b0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < NPROP; i++) begin
        rng_start[i] <= '0;
        rng_end[i]   <= '0;
        val[i]       <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_DURATION) begin
          duration <= cfg_data[TW-1:0];
        end
        for (int i = 0; i < NPROP; i++) begin
          if (cfg_index == REG_RANGE_BASE + CFG_INDEX_BITS'(i)) begin
            rng_start[i] <= cfg_data[VB-1:0];
            rng_end[i]   <= cfg_data[HALF_BITS+VB-1:HALF_BITS];
            val[i]       <= cfg_data[VB-1:0];
          end
        end
      end

      if (in_acc) begin
        fin    <= 1'b0;
        interp <= 1'b0;
        unique case (cmd_t'(s_tuser))
          CMD_TICK: begin
            fin <= 1'b1;
            if (active) begin
              if (sum >= {1'b0, duration}) begin
                elapsed <= duration;
                active  <= 1'b0;
                for (int i = 0; i < NPROP; i++) val[i] <= rng_end[i];
              end else begin
                elapsed <= sum[TW-1:0];
                interp  <= 1'b1;
                fin     <= 1'b0;
              end
            end
          end
          CMD_START: begin
            active  <= 1'b1;
            elapsed <= '0;
          end
          CMD_STOP: begin
            active <= 1'b0;
          end
          CMD_RESET: begin
            elapsed <= '0;
            for (int i = 0; i < NPROP; i++) val[i] <= rng_start[i];
          end
          default: ;
        endcase
      end

      if (div_done) prog <= div_q;
      if (sqr_done) ease <= ease_next;
      if (state == ST_MUL_WAIT && (&mul_done)) begin
        for (int i = 0; i < NPROP; i++) val[i] <= blend_val[i];
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {{OUT_PAD_BITS{1'b0}}, fin, active, prog,
                     OUT_VALUE_BITS'(signed'(val[3])),
                     OUT_VALUE_BITS'(signed'(val[2])),
                     OUT_VALUE_BITS'(signed'(val[1])),
                     OUT_VALUE_BITS'(signed'(val[0]))};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------ assertions
  a_accept_starts_div: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == ST_DIV_GO)
    else $error("accepted command did not start the divider");

  a_blend_only_running: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQR_WAIT || state == ST_MUL_WAIT) |-> (active && interp && !fin))
    else $error("interpolation running while the tween is stopped");

  a_finished_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && fin) |-> !active)
    else $error("finished flag set while running");

  a_prog_range: assert property (@(posedge clk) disable iff (rst)
    out_load |-> prog <= PROG_ONE)
    else $error("progress above one");

endmodule

@@ sim/eased_tween_engine_top_test.sv @@
`timescale 1ns / 1ps

module eased_tween_engine_top_test;
  import etw_pkg::*;

  localparam int SETTLE_CYCLES = 100;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 240;
  localparam int PROG_LSB      = NPROP * OUT_VALUE_BITS;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_BASE = CFG_INDEX_BITS'(REG_RANGE_BASE + NPROP);

  typedef struct packed {
    logic [NPROP-1:0][OUT_VALUE_BITS-1:0] value;
    logic [PROG_W-1:0]                    progress;
    logic                                 running;
    logic                                 finished;
  } tween_frame_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]   cfg_data = '0;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [IN_DATA_BITS-1:0]    s_tdata = '0;
  logic [CMD_BITS-1:0]        s_tuser = '0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0]   m_tdata;

  // shadow of the engine state
  logic [DUR_FIELD_BITS-1:0]  dur_q = '0;
  logic [CFG_DATA_BITS-1:0]   range_q [NPROP];
  logic [DELTA_BITS-1:0]      elapsed_q = '0;
  logic                       active_q = 1'b0;
  logic [OUT_VALUE_BITS-1:0]  value_q [NPROP];

  tween_frame_t pending_frames [$];
  int mismatch_count = 0;
  int burst_left = 0;
  int rx_hold = 0;
  int rx_mode = 0;
  int rx_left = 0;

  eased_tween_engine_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < NPROP; i++) begin
      range_q[i] = '0;
      value_q[i] = '0;
    end
  end

  function automatic logic [PROG_W-1:0] tween_progress();
    longint unsigned q;
    if (dur_q == 0) return '0;
    q = 64'(elapsed_q);
    q = (q << PROG_BITS) / dur_q;
    return (q > 65536) ? PROG_ONE : q[PROG_W-1:0];
  endfunction

  function automatic tween_frame_t advance_tween(cmd_t cmd, logic [DELTA_BITS-1:0] delta);
    tween_frame_t f;
    logic [DELTA_BITS:0] sum;
    longint unsigned p, ease, mag, off;
    longint s, e, diff;
    f = '0;
    case (cmd)
      CMD_TICK: begin
        if (active_q) begin
          sum = {1'b0, elapsed_q} + {1'b0, delta};
          if (sum >= {1'b0, dur_q}) begin
            elapsed_q = dur_q;
            active_q  = 1'b0;
            for (int i = 0; i < NPROP; i++) value_q[i] = range_q[i][63:32];
          end else begin
            elapsed_q = sum[DELTA_BITS-1:0];
            p = 64'(tween_progress());
            if (p < 32768) ease = 2 * p * p;
            else ease = (64'd1 << 32) - 2 * (65536 - p) * (65536 - p);
            for (int i = 0; i < NPROP; i++) begin
              s    = 64'($signed(range_q[i][31:0]));
              e    = 64'($signed(range_q[i][63:32]));
              diff = e - s;
              mag  = (diff < 0) ? -diff : diff;
              off  = (mag * ease) >> 32;
              value_q[i] = OUT_VALUE_BITS'((diff < 0) ? s - longint'(off) : s + longint'(off));
            end
          end
        end
        f.finished = !active_q;
      end
      CMD_START: begin
        active_q  = 1'b1;
        elapsed_q = '0;
      end
      CMD_STOP: active_q = 1'b0;
      default: begin
        elapsed_q = '0;
        for (int i = 0; i < NPROP; i++) value_q[i] = range_q[i][31:0];
      end
    endcase
    for (int i = 0; i < NPROP; i++) f.value[i] = value_q[i];
    f.progress = tween_progress();
    f.running  = active_q;
    return f;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("%0t ns: %s expected %h got %h", $time, what, want, got);
    mismatch_count++;
  endtask

  // engine must be idle
  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    int k;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_DURATION) begin
      dur_q = data[DUR_FIELD_BITS-1:0];
    end else if (idx >= REG_RANGE_BASE && idx < REG_UNUSED_BASE) begin
      k = int'(idx - REG_RANGE_BASE);
      range_q[k] = data;
      value_q[k] = data[31:0];
    end
  endtask

  task automatic send_command(cmd_t cmd, logic [DELTA_BITS-1:0] delta);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= delta;
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
    pending_frames.push_back(advance_tween(cmd, delta));
  endtask

  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    while (pending_frames.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_BITS-1:0] pick_range();
    logic [31:0] a;
    a = $urandom;
    if ($urandom_range(0, 3) != 0) return {32'($urandom), a};
    case ($urandom_range(0, 3))
      0: return {32'h7FFF_FFFF, 32'h8000_0000};
      1: return {32'h8000_0000, 32'h7FFF_FFFF};
      2: return {a, a};
      default: return {32'($urandom_range(0, 32'h0002_0000)), 32'h0};
    endcase
  endfunction

  task automatic configure_phase(logic [DUR_FIELD_BITS-1:0] dur);
    write_reg(REG_DURATION, CFG_DATA_BITS'(dur));
    for (int i = 0; i < NPROP; i++)
      write_reg(CFG_INDEX_BITS'(REG_RANGE_BASE + i), pick_range());
  endtask

  // mostly start/tick runs to completion, some stop/reset and random noise
  task automatic run_random_phase(int count);
    int r;
    cmd_t cmd;
    logic [DELTA_BITS-1:0] delta;
    repeat (count) begin
      r = $urandom_range(0, 99);
      delta = (dur_q == 0) ? DELTA_BITS'($urandom) : DELTA_BITS'($urandom_range(0, dur_q / 6 + 1));
      if (r < 8) begin
        cmd   = cmd_t'($urandom_range(0, 3));
        delta = DELTA_BITS'($urandom);
      end else if (!active_q) begin
        cmd = (r < 14) ? CMD_TICK : CMD_START;
      end else if (r < 90) begin
        cmd = CMD_TICK;
      end else if (r < 93) begin
        cmd   = CMD_TICK;
        delta = DELTA_BITS'($urandom);
      end else if (r < 97) begin
        cmd = CMD_RESET;
      end else begin
        cmd = CMD_STOP;
      end
      send_command(cmd, delta);
    end
  endtask

  task automatic test_idle_and_zero_duration();
    send_command(CMD_TICK, '0);
    wait_quiet();
    write_reg(CFG_INDEX_BITS'(REG_RANGE_BASE + 0), {32'h7FFF_FFFF, 32'h8000_0000});
    write_reg(CFG_INDEX_BITS'(REG_RANGE_BASE + 1), {32'h8000_0000, 32'h7FFF_FFFF});
    write_reg(CFG_INDEX_BITS'(REG_RANGE_BASE + 2), {32'h1234_5678, 32'h1234_5678});
    write_reg(CFG_INDEX_BITS'(REG_RANGE_BASE + 3), {32'h0001_0000, 32'h0000_0000});
    write_reg(REG_DURATION, '0);
    send_command(CMD_START, '0);
    send_command(CMD_TICK, '0);
    send_command(CMD_RESET, '0);
    send_command(CMD_STOP, '0);
    send_command(CMD_TICK, 16'hFFFF);
    wait_quiet();
  endtask

  // walks across the half-way switch of the curve, then overflows elapsed
  task automatic test_long_sweep();
    write_reg(REG_DURATION, 64'hFFFF);
    send_command(CMD_START, '0);
    send_command(CMD_TICK, 16'd1);
    send_command(CMD_TICK, 16'd32766);
    send_command(CMD_TICK, 16'd1);
    send_command(CMD_TICK, 16'd32765);
    send_command(CMD_TICK, 16'hFFFF);
    send_command(CMD_TICK, '0);
    send_command(CMD_START, '0);
    send_command(CMD_TICK, 16'd100);
    send_command(CMD_RESET, '0);
    send_command(CMD_TICK, 16'd100);
    wait_quiet();
  endtask

  task automatic test_shortened_duration();
    write_reg(REG_DURATION, 64'd1000);
    send_command(CMD_START, '0);
    send_command(CMD_TICK, 16'd900);
    wait_quiet();
    write_reg(REG_DURATION, 64'd100);
    send_command(CMD_STOP, '0);
    send_command(CMD_START, '0);
    send_command(CMD_TICK, 16'd90);
    wait_quiet();
    write_reg(REG_DURATION, 64'd50);
    send_command(CMD_TICK, 16'd1);
    wait_quiet();
  endtask

  task automatic test_unused_register_index();
    for (int i = 0; i < 8 - REG_UNUSED_BASE; i++)
      write_reg(CFG_INDEX_BITS'(REG_UNUSED_BASE + i), {32'($urandom), 32'($urandom)});
    send_command(CMD_RESET, '0);
    send_command(CMD_TICK, '0);
    send_command(CMD_START, '0);
    send_command(CMD_TICK, 16'd20);
    wait_quiet();
  endtask

  task automatic test_random_phases();
    logic [DUR_FIELD_BITS-1:0] dur;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: dur = '0;
        1: dur = 16'hFFFF;
        2: dur = 16'd1;
        default: dur = ($urandom_range(0, 3) == 0) ? DUR_FIELD_BITS'($urandom)
                                                    : DUR_FIELD_BITS'($urandom_range(2, 400));
      endcase
      configure_phase(dur);
      run_random_phase(PHASE_ITEMS);
      wait_quiet();
    end
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_output_backpressure();
    configure_phase(16'd200);
    rx_hold    = 400;
    burst_left = 64;
    run_random_phase(48);
    wait_quiet();
  endtask

  always @(posedge clk) begin : rx_pattern
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 1) == 1);
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    tween_frame_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_frames.size() == 0) begin
        flag_mismatch("unexpected result transaction", '0, '0);
      end else begin
        want = pending_frames.pop_front();
        for (int i = 0; i < NPROP; i++)
          if (m_tdata[i*OUT_VALUE_BITS +: OUT_VALUE_BITS] !== want.value[i])
            flag_mismatch($sformatf("value %0d", i), want.value[i],
                          m_tdata[i*OUT_VALUE_BITS +: OUT_VALUE_BITS]);
        if (m_tdata[PROG_LSB +: PROG_W] !== want.progress)
          flag_mismatch("progress", 32'(want.progress), 32'(m_tdata[PROG_LSB +: PROG_W]));
        if (m_tdata[PROG_LSB + PROG_W] !== want.running)
          flag_mismatch("running", 32'(want.running), 32'(m_tdata[PROG_LSB + PROG_W]));
        if (m_tdata[PROG_LSB + PROG_W + 1] !== want.finished)
          flag_mismatch("finished", 32'(want.finished), 32'(m_tdata[PROG_LSB + PROG_W + 1]));
        if (m_tdata[OUT_DATA_BITS-1:OUT_USED_BITS] !== '0)
          flag_mismatch("padding", '0, 32'(m_tdata[OUT_DATA_BITS-1:OUT_USED_BITS]));
      end
    end
  end

  initial begin
    #40_000_000;
    $display("eased_tween_engine_top: mismatch");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_idle_and_zero_duration();
    test_long_sweep();
    test_shortened_duration();
    test_unused_register_index();
    test_random_phases();
    test_output_backpressure();
    if (mismatch_count == 0) begin
      $display("eased_tween_engine_top: match");
    end else begin
      $display("eased_tween_engine_top: mismatch");
    end
    $finish;
  end

endmodule
